[hw/rtl/pqe_pkg.sv]
package pqe_pkg;

  // default sizes
  localparam int DEF_MAX_CENTROIDS  = 256;
  localparam int DEF_MAX_SUBSPACES  = 16;
  localparam int DEF_MAX_SUB_LENGTH = 8;
  localparam int DEF_VALUE_WIDTH    = 16;

  // fixed field widths
  localparam int SUBSPACE_W = 4;
  localparam int CENTROID_W = 8;
  localparam int ELEMENT_W  = 3;
  localparam int CODE_W     = 8;

  // configuration register widths
  localparam int NSUB_W     = 5;
  localparam int NCEN_W     = 9;
  localparam int SLEN_W     = 4;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUBSPACE_COUNT = 2'd0,
    CFG_CENTROID_COUNT = 2'd1,
    CFG_SUB_LENGTH     = 2'd2
  } cfg_idx_t;

  // request types
  typedef enum logic {
    REQ_BOOK = 1'b0,
    REQ_DATA = 1'b1
  } req_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2
  } state_t;

endpackage

[hw/rtl/product_quantizer_encoder_top.sv]
// product quantizer encoder
// input channel (in_valid/in_ready) carries two kinds of transfer:
//   req_type book: writes one codebook element at book_subspace/centroid/element,
//     taken while the block is idle, writes beyond the parameter maxima are dropped
//   req_type data: one element of the data vector; the block walks every
//     centroid of the current subspace, one per cycle, through a
//     read-modify-write of the partial distance memory
// a data transfer keeps the block busy until it returns to idle: the
// centroid scan issues one codebook read and one distance read per cycle,
// followed by a three stage subtract/square/accumulate pipe and a drain state
// the element that completes a subvector yields one result transfer on the
// out_ channel after the scan, once the pipe has drained: nearest centroid
// (lowest index on a tie), its subspace and a flag on the last code of the vector
// the result sits in an output register; while it waits for out_ready the
// block keeps taking codebook writes and data elements that finish no
// subvector, a finishing element holds in the drain state until it is free
// cfg_we to a defined index writes a register at once and restarts the vector
// (positions to zero); distances need no clearing since the first element of a
// subvector overwrites them. reset is synchronous: registers to their defaults,
// positions to zero, no pending result; codebook contents are kept undefined
module product_quantizer_encoder_top
  import pqe_pkg::*;
#(
  parameter int MAX_CENTROIDS  = DEF_MAX_CENTROIDS,
  parameter int MAX_SUBSPACES  = DEF_MAX_SUBSPACES,
  parameter int MAX_SUB_LENGTH = DEF_MAX_SUB_LENGTH,
  parameter int VALUE_WIDTH    = DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [SUBSPACE_W-1:0]         in_book_subspace,
  input  logic [CENTROID_W-1:0]         in_book_centroid,
  input  logic [ELEMENT_W-1:0]          in_book_element,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CODE_W-1:0]             out_code,
  output logic [SUBSPACE_W-1:0]         out_code_subspace,
  output logic                          out_last_of_vector,
  // configuration
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int BOOK_DEPTH = MAX_SUBSPACES * MAX_CENTROIDS * MAX_SUB_LENGTH;
  localparam int BOOK_AW    = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int CEN_AW     = $clog2(MAX_CENTROIDS);
  localparam int CEN_CW     = CEN_AW + 1;
  localparam int SUB_AW     = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1;
  localparam int SUB_CW     = SUB_AW + 1;
  localparam int EL_AW      = (MAX_SUB_LENGTH > 1) ? $clog2(MAX_SUB_LENGTH) : 1;
  localparam int EL_CW      = EL_AW + 1;
  localparam int SQ_W       = 2 * VALUE_WIDTH;
  localparam int DIST_FULL  = SQ_W + $clog2(MAX_SUB_LENGTH);
  localparam int DIST_W     = (DIST_FULL > 64) ? 64 : DIST_FULL;
  localparam int SUB_STRIDE = MAX_CENTROIDS * MAX_SUB_LENGTH;

  // ---------------------------------------------------------------------------
  // configuration registers and their clamped forms
  // ---------------------------------------------------------------------------
  logic [NSUB_W-1:0] nsub_raw_r;
  logic [NCEN_W-1:0] ncen_raw_r;
  logic [SLEN_W-1:0] slen_raw_r;
  logic [SUB_CW-1:0] nsub;
  logic [CEN_CW-1:0] ncen;
  logic [EL_CW-1:0]  slen;

  always_comb begin
    if (nsub_raw_r == '0) begin
      nsub = SUB_CW'(1);
    end else if (int'(nsub_raw_r) > MAX_SUBSPACES) begin
      nsub = SUB_CW'(MAX_SUBSPACES);
    end else begin
      nsub = SUB_CW'(nsub_raw_r);
    end
    if (ncen_raw_r == '0) begin
      ncen = CEN_CW'(1);
    end else if (int'(ncen_raw_r) > MAX_CENTROIDS) begin
      ncen = CEN_CW'(MAX_CENTROIDS);
    end else begin
      ncen = CEN_CW'(ncen_raw_r);
    end
    if (slen_raw_r == '0) begin
      slen = EL_CW'(1);
    end else if (int'(slen_raw_r) > MAX_SUB_LENGTH) begin
      slen = EL_CW'(MAX_SUB_LENGTH);
    end else begin
      slen = EL_CW'(slen_raw_r);
    end
  end

  logic cfg_hit;

  always_comb begin
    unique case (cfg_index)
      CFG_SUBSPACE_COUNT,
      CFG_CENTROID_COUNT,
      CFG_SUB_LENGTH:     cfg_hit = cfg_we;
      default:            cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nsub_raw_r <= NSUB_W'(1);
      ncen_raw_r <= NCEN_W'(256);
      slen_raw_r <= SLEN_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SUBSPACE_COUNT: nsub_raw_r <= cfg_wdata[NSUB_W-1:0];
        CFG_CENTROID_COUNT: ncen_raw_r <= cfg_wdata[NCEN_W-1:0];
        CFG_SUB_LENGTH:     slen_raw_r <= cfg_wdata[SLEN_W-1:0];
        default:            ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic [CEN_AW-1:0]  cnt_r;
  logic               cnt_last;
  logic               pipe_empty;
  logic               out_free;
  logic               in_fire;
  logic               data_fire;
  logic               book_fire;
  logic               scan_issue;
  logic               emit;
  logic               final_r;

  logic v1_r, v2_r, v3_r;

  assign cnt_last   = ({1'b0, cnt_r} == (ncen - CEN_CW'(1)));
  assign pipe_empty = !v1_r && !v2_r && !v3_r;
  assign out_free   = !out_valid || out_ready;
  assign in_fire    = in_valid && in_ready;
  assign data_fire  = in_fire && (in_req_type == REQ_DATA);
  assign book_fire  = in_fire && (in_req_type == REQ_BOOK);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (data_fire) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (pipe_empty && (!final_r || out_free)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    scan_issue = 1'b0;
    emit       = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready   = 1'b1;
      ST_SCAN:  scan_issue = 1'b1;
      ST_FLUSH: emit       = pipe_empty && final_r && out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // vector position tracking, advanced when a data element is taken
  // ---------------------------------------------------------------------------
  logic [EL_AW-1:0]  elem_pos_r;
  logic [SUB_AW-1:0] sub_pos_r;
  logic              elem_final;
  logic              sub_last;

  assign elem_final = ({1'b0, elem_pos_r} + EL_CW'(1)) >= slen;
  assign sub_last   = ({1'b0, sub_pos_r} + SUB_CW'(1)) >= nsub;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      elem_pos_r <= '0;
      sub_pos_r  <= '0;
    end else if (data_fire) begin
      if (elem_final) begin
        elem_pos_r <= '0;
        sub_pos_r  <= sub_last ? '0 : sub_pos_r + SUB_AW'(1);
      end else begin
        elem_pos_r <= elem_pos_r + EL_AW'(1);
      end
    end
  end

  // per-item context
  logic signed [VALUE_WIDTH-1:0] x_r;
  logic                          first_r;
  logic                          last_r;
  logic [SUB_AW-1:0]             cur_sub_r;
  logic [BOOK_AW-1:0]            rd_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      final_r <= 1'b0;
    end else if (data_fire) begin
      final_r <= elem_final;
    end
  end

  always_ff @(posedge clk) begin
    if (data_fire) begin
      x_r       <= in_value;
      first_r   <= (elem_pos_r == '0);
      last_r    <= sub_last;
      cur_sub_r <= sub_pos_r;
      rd_addr_r <= BOOK_AW'(sub_pos_r) * BOOK_AW'(SUB_STRIDE) + BOOK_AW'(elem_pos_r);
    end else if (scan_issue) begin
      rd_addr_r <= rd_addr_r + BOOK_AW'(MAX_SUB_LENGTH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (data_fire) begin
      cnt_r <= '0;
    end else if (scan_issue && !cnt_last) begin
      cnt_r <= cnt_r + CEN_AW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // codebook memory: written by book transfers, read during the scan
  // ---------------------------------------------------------------------------
  logic signed [VALUE_WIDTH-1:0] book_mem [BOOK_DEPTH];
  logic signed [VALUE_WIDTH-1:0] book_rdata_r;
  logic                          book_in_range;
  logic [BOOK_AW-1:0]            wr_addr;

  assign book_in_range = (int'(in_book_subspace) < MAX_SUBSPACES) &&
                         (int'(in_book_centroid) < MAX_CENTROIDS) &&
                         (int'(in_book_element) < MAX_SUB_LENGTH);
  assign wr_addr = BOOK_AW'(in_book_subspace) * BOOK_AW'(SUB_STRIDE) +
                   BOOK_AW'(in_book_centroid) * BOOK_AW'(MAX_SUB_LENGTH) +
                   BOOK_AW'(in_book_element);

  always_ff @(posedge clk) begin
    if (book_fire && book_in_range) begin
      book_mem[wr_addr] <= in_value;
    end
    if (scan_issue) begin
      book_rdata_r <= book_mem[rd_addr_r];
    end
  end

  // ---------------------------------------------------------------------------
  // partial distance memory, one entry per centroid
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0] dist_mem [MAX_CENTROIDS];
  logic [DIST_W-1:0] dist_rdata_r;
  logic              dist_we;
  logic [CEN_AW-1:0] c3_r;
  logic [DIST_W-1:0] dist_new;

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[c3_r] <= dist_new;
    end
    if (scan_issue) begin
      dist_rdata_r <= dist_mem[cnt_r];
    end
  end

  // ---------------------------------------------------------------------------
  // subtract, square, accumulate
  // ---------------------------------------------------------------------------
  logic [CEN_AW-1:0]              c1_r, c2_r;
  logic signed [VALUE_WIDTH:0]    diff;
  logic [VALUE_WIDTH-1:0]         mag;
  logic [VALUE_WIDTH-1:0]         mag_r;
  logic [DIST_W-1:0]              acc2_r, acc3_r;
  logic [SQ_W-1:0]                sq_r;
  logic [DIST_W:0]                sum_ext;
  logic [DIST_W-1:0]              best_dist_r;
  logic [CEN_AW-1:0]              best_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= scan_issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_comb begin
    diff = {x_r[VALUE_WIDTH-1], x_r} - {book_rdata_r[VALUE_WIDTH-1], book_rdata_r};
    if (diff[VALUE_WIDTH]) begin
      mag = VALUE_WIDTH'(-diff);
    end else begin
      mag = VALUE_WIDTH'(diff);
    end
  end

  always_ff @(posedge clk) begin
    c1_r   <= cnt_r;
    mag_r  <= mag;
    acc2_r <= first_r ? '0 : dist_rdata_r;
    c2_r   <= c1_r;
    sq_r   <= mag_r * mag_r;
    acc3_r <= acc2_r;
    c3_r   <= c2_r;
  end

  // saturating accumulate; the carry only appears at the 64-bit cap
  assign sum_ext  = {1'b0, acc3_r} + (DIST_W + 1)'(sq_r);
  assign dist_new = sum_ext[DIST_W] ? '1 : sum_ext[DIST_W-1:0];
  assign dist_we  = v3_r;

  // running minimum over the scan, strict compare keeps the lowest index
  always_ff @(posedge clk) begin
    if (v3_r && ((c3_r == '0) || (dist_new < best_dist_r))) begin
      best_dist_r <= dist_new;
      best_idx_r  <= c3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic                  out_valid_r;
  logic [CODE_W-1:0]     out_code_r;
  logic [SUBSPACE_W-1:0] out_sub_r;
  logic                  out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_code_r <= CODE_W'(best_idx_r);
      out_sub_r  <= SUBSPACE_W'(cur_sub_r);
      out_last_r <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_code           = out_code_r;
  assign out_code_subspace  = out_sub_r;
  assign out_last_of_vector = out_last_r;

endmodule
